@@ hdl/ancestor_threshold_search_assert.svh @@
// assertion macros shared by the ancestor threshold search rtl
`ifndef ANCESTOR_THRESHOLD_SEARCH_ASSERT_SVH
`define ANCESTOR_THRESHOLD_SEARCH_ASSERT_SVH
`ifndef ASSERT_OFF
// concurrent assertion on a named clock and active-low reset
`define ATS_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed in %m");
// same, on the block clock and reset
`define ATS_ASSERT(lbl, prop) `ATS_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)
`else
`define ATS_ASSERT_CLK(lbl, clk, rst_n, prop)
`define ATS_ASSERT(lbl, prop)
`endif
`endif

@@ hdl/ats_pkg.sv @@
// shared constants for the ancestor threshold search block
package ats_pkg;

    localparam int MAX_NODES_DEF   = 1024;
    localparam int JUMP_LEVELS_DEF = 10;

    localparam int ACTION_W = 1;
    localparam int NODE_PW  = 10;
    localparam int VALUE_W  = 32;
    localparam int CNT_PW   = 11;

    localparam logic [ACTION_W-1:0] ACTION_LOAD  = 1'b0;
    localparam logic [ACTION_W-1:0] ACTION_QUERY = 1'b1;

endpackage

@@ hdl/ats_ram.sv @@
// generic simple dual-port ram with registered read
module ats_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/ancestor_threshold_search.sv @@
// ancestor threshold search: tree store, jump table build and query sequencer
//
// A load (action 0) is taken on its start beat and never raises busy. A query (action 1)
// raises busy, unless the table is built and the node is at or above node_count, and
// gives its ancestor on a one-cycle o_valid strobe, which the receiver cannot hold
// off; busy drops in the same cycle the strobe shows. With L = min(floor(log2
// node_count), JUMP_LEVELS-1), a query walks levels L down to 0 through the jump
// table ram, one link read and at most one value read per level. A query that
// starts at or above node_count while the table is built strobes in the next cycle.
// The first query after a load or a node_count write first rebuilds the jump table:
// the parent level one entry at a time (S_L0), then the gap state S_LGAP, then each
// higher level (S_BMID and S_BWR, up to two dependent reads of the same ram per
// entry), then the state S_QGO before the walk begins.
`include "ancestor_threshold_search_assert.svh"

module ancestor_threshold_search #(
    parameter int MAX_NODES   = ats_pkg::MAX_NODES_DEF,
    parameter int JUMP_LEVELS = ats_pkg::JUMP_LEVELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ats_pkg::ACTION_W-1:0]  i_action,
    input  logic [ats_pkg::NODE_PW-1:0]   i_node,
    input  logic [ats_pkg::NODE_PW-1:0]   i_parent,
    input  logic [ats_pkg::VALUE_W-1:0]   i_node_value,
    input  logic [ats_pkg::VALUE_W-1:0]   i_threshold,
    input  logic                          i_cfg_we,
    input  logic [ats_pkg::CNT_PW-1:0]    i_cfg_wdata,
    output logic                          o_valid,
    output logic [ats_pkg::NODE_PW-1:0]   o_ancestor
);

    localparam int NODE_W   = $clog2(MAX_NODES);
    localparam int CNT_W    = $clog2(MAX_NODES + 1);
    localparam int LINK_W   = CNT_W;
    localparam int LVL_W    = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
    localparam int JL_ROWS  = (JUMP_LEVELS > 1) ? JUMP_LEVELS : 2;
    localparam int JL_DEPTH = JL_ROWS * (2 ** NODE_W);
    localparam int JL_AW    = LVL_W + NODE_W;
    localparam int OUT_W    = ats_pkg::NODE_PW;
    localparam int VAL_W    = ats_pkg::VALUE_W;
    localparam int CFG_W    = ats_pkg::CNT_PW;

    localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(MAX_NODES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_L0   = 3'd1;
    localparam logic [2:0] S_LGAP = 3'd2;
    localparam logic [2:0] S_BMID = 3'd3;
    localparam logic [2:0] S_BWR  = 3'd4;
    localparam logic [2:0] S_QGO  = 3'd5;
    localparam logic [2:0] S_QT   = 3'd6;
    localparam logic [2:0] S_QV   = 3'd7;

    function automatic logic [CNT_W-1:0] f_active(input logic [CFG_W-1:0] cnt);
        logic [CNT_W-1:0] res;
        if (cnt == '0) begin
            res = CNT_W'(1);
        end else if (32'(cnt) > 32'(MAX_NODES)) begin
            res = CNT_W'(MAX_NODES);
        end else begin
            res = CNT_W'(cnt);
        end
        return res;
    endfunction

    function automatic logic [LVL_W-1:0] f_top(input logic [CNT_W-1:0] cnt);
        int lvl;
        lvl = 0;
        for (int b = 0; b < CNT_W; b++) begin
            if (cnt[b]) begin
                lvl = b;
            end
        end
        if (lvl > JUMP_LEVELS - 1) begin
            lvl = JUMP_LEVELS - 1;
        end
        return LVL_W'(lvl);
    endfunction

    logic [2:0]        r_state, n_state;
    logic              r_ready, n_ready;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [NODE_W-1:0] r_nm1, n_nm1;
    logic [LVL_W-1:0]  r_top, n_top;
    logic [NODE_W-1:0] r_i, n_i;
    logic [LVL_W-1:0]  r_j, n_j;
    logic [NODE_W-1:0] r_k, n_k;
    logic [NODE_W-1:0] r_t, n_t;
    logic [VAL_W-1:0]  r_thr, n_thr;
    logic [OUT_W-1:0]  r_qnode, n_qnode;
    logic              r_wpend, n_wpend;
    logic [NODE_W-1:0] r_widx, n_widx;
    logic              r_out_vld, n_out_vld;
    logic [OUT_W-1:0]  r_out, n_out;

    logic              acc;
    logic              load_we;
    logic [NODE_W-1:0] ld_addr;
    logic [CNT_W-1:0]  cfg_n;

    logic              jl_we;
    logic [JL_AW-1:0]  jl_waddr;
    logic [LINK_W-1:0] jl_wdata;
    logic [JL_AW-1:0]  jl_raddr;
    logic [LINK_W-1:0] jl_rdata;
    logic [NODE_W-1:0] val_raddr;
    logic [VAL_W-1:0]  val_rdata;
    logic [NODE_W-1:0] par_raddr;
    logic [OUT_W-1:0]  par_rdata;

    logic              q_begin;
    logic [OUT_W-1:0]  q_node;
    logic              q_step;
    logic              q_take;
    logic [NODE_W-1:0] q_target;
    logic [NODE_W-1:0] k_new;
    logic              nxt_entry;

    logic              in_walk;
    logic              in_qv;
    logic [LVL_W-1:0]  j_dn;

    assign busy    = (r_state != S_IDLE);
    assign acc     = start && !busy;
    assign load_we = acc && (i_action == ats_pkg::ACTION_LOAD) && (i_node != '0)
                     && (32'(i_node) < 32'(MAX_NODES));
    assign ld_addr = NODE_W'(i_node);
    assign cfg_n   = f_active(i_cfg_wdata);
    assign q_node  = (r_state == S_IDLE) ? i_node : r_qnode;

    ats_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NODES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (ld_addr),
        .i_wdata (i_node_value),
        .i_raddr (val_raddr),
        .o_rdata (val_rdata)
    );

    ats_ram #(.WIDTH(OUT_W), .DEPTH(MAX_NODES)) u_par_ram (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (ld_addr),
        .i_wdata (i_parent),
        .i_raddr (par_raddr),
        .o_rdata (par_rdata)
    );

    ats_ram #(.WIDTH(LINK_W), .DEPTH(JL_DEPTH)) u_jl_ram (
        .i_clk   (i_clk),
        .i_we    (jl_we),
        .i_waddr (jl_waddr),
        .i_wdata (jl_wdata),
        .i_raddr (jl_raddr),
        .o_rdata (jl_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_ready   = r_ready;
        n_n       = r_n;
        n_nm1     = r_nm1;
        n_top     = r_top;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_t       = r_t;
        n_thr     = r_thr;
        n_qnode   = r_qnode;
        n_wpend   = 1'b0;
        n_widx    = r_widx;
        n_out_vld = 1'b0;
        n_out     = r_out;
        jl_we     = 1'b0;
        jl_waddr  = {r_j, r_i};
        jl_wdata  = NO_LINK;
        jl_raddr  = '0;
        val_raddr = '0;
        par_raddr = r_i;
        q_begin   = 1'b0;
        q_step    = 1'b0;
        q_take    = 1'b0;
        q_target  = r_t;
        nxt_entry = 1'b0;

        // parent level: the parent read issued last cycle lands here
        if (r_wpend) begin
            jl_we    = 1'b1;
            jl_waddr = {LVL_W'(0), r_widx};
            jl_wdata = ((r_widx == '0) || (32'(par_rdata) >= 32'(r_n))) ?
                       NO_LINK : LINK_W'(par_rdata);
        end

        case (r_state)
            S_IDLE: begin
                if (acc && (i_action == ats_pkg::ACTION_QUERY)) begin
                    n_thr   = i_threshold;
                    n_qnode = i_node;
                    if (r_ready) begin
                        q_begin = 1'b1;
                    end else begin
                        n_i     = '0;
                        n_state = S_L0;
                    end
                end
            end
            S_L0: begin
                n_wpend = 1'b1;
                n_widx  = r_i;
                if (r_i == r_nm1) begin
                    n_state = S_LGAP;
                end else begin
                    n_i = r_i + NODE_W'(1);
                end
            end
            S_LGAP: begin
                if (r_top == '0) begin
                    n_state = S_QGO;
                end else begin
                    n_j      = LVL_W'(1);
                    n_i      = '0;
                    jl_raddr = '0;
                    n_state  = S_BMID;
                end
            end
            S_BMID: begin
                // jl_rdata is the level j-1 link of entry i
                if (jl_rdata < r_n) begin
                    jl_raddr = {r_j - LVL_W'(1), NODE_W'(jl_rdata)};
                    n_state  = S_BWR;
                end else begin
                    jl_we     = 1'b1;
                    jl_waddr  = {r_j, r_i};
                    jl_wdata  = NO_LINK;
                    nxt_entry = 1'b1;
                end
            end
            S_BWR: begin
                jl_we     = 1'b1;
                jl_waddr  = {r_j, r_i};
                jl_wdata  = jl_rdata;
                nxt_entry = 1'b1;
            end
            S_QGO: begin
                // entered after the last table write so the walk never reads it back
                n_ready = 1'b1;
                q_begin = 1'b1;
            end
            S_QT: begin
                if (jl_rdata < r_n) begin
                    if (jl_rdata == '0) begin
                        // root value is fixed at one
                        q_step   = 1'b1;
                        q_target = '0;
                        q_take   = (r_thr <= VAL_W'(1));
                    end else begin
                        val_raddr = NODE_W'(jl_rdata);
                        n_t       = NODE_W'(jl_rdata);
                        n_state   = S_QV;
                    end
                end else begin
                    q_step = 1'b1;
                end
            end
            S_QV: begin
                q_step   = 1'b1;
                q_target = r_t;
                q_take   = (val_rdata >= r_thr);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (nxt_entry) begin
            if (r_i == r_nm1) begin
                if (r_j == r_top) begin
                    n_state = S_QGO;
                end else begin
                    n_j      = r_j + LVL_W'(1);
                    n_i      = '0;
                    jl_raddr = {r_j, NODE_W'(0)};
                    n_state  = S_BMID;
                end
            end else begin
                n_i      = r_i + NODE_W'(1);
                jl_raddr = {r_j - LVL_W'(1), r_i + NODE_W'(1)};
                n_state  = S_BMID;
            end
        end

        if (q_begin) begin
            if (32'(q_node) >= 32'(r_n)) begin
                n_out_vld = 1'b1;
                n_out     = q_node;
                n_state   = S_IDLE;
            end else begin
                n_k      = NODE_W'(q_node);
                n_j      = r_top;
                jl_raddr = {r_top, NODE_W'(q_node)};
                n_state  = S_QT;
            end
        end

        k_new = q_take ? q_target : r_k;
        if (q_step) begin
            n_k = k_new;
            if (r_j == '0) begin
                n_out_vld = 1'b1;
                n_out     = OUT_W'(k_new);
                n_state   = S_IDLE;
            end else begin
                n_j      = r_j - LVL_W'(1);
                jl_raddr = {r_j - LVL_W'(1), k_new};
                n_state  = S_QT;
            end
        end

        if (load_we) begin
            n_ready = 1'b0;
        end
        if (i_cfg_we) begin
            n_n     = cfg_n;
            n_nm1   = NODE_W'(cfg_n - CNT_W'(1));
            n_top   = f_top(cfg_n);
            n_ready = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ready   <= 1'b0;
            r_n       <= CNT_W'(1);
            r_nm1     <= '0;
            r_top     <= '0;
            r_wpend   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ready   <= n_ready;
            r_n       <= n_n;
            r_nm1     <= n_nm1;
            r_top     <= n_top;
            r_wpend   <= n_wpend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_t     <= n_t;
        r_thr   <= n_thr;
        r_qnode <= n_qnode;
        r_widx  <= n_widx;
        r_out   <= n_out;
    end

    assign o_valid    = r_out_vld;
    assign o_ancestor = r_out;

    assign in_walk = (r_state == S_QT) || (r_state == S_QV) || (r_state == S_QGO);
    assign in_qv   = (r_state == S_QV);
    assign j_dn    = r_j - LVL_W'(1);

    `ATS_ASSERT(a_valid_when_idle, o_valid |-> !busy)
    `ATS_ASSERT(a_load_one_beat, (acc && (i_action == ats_pkg::ACTION_LOAD)) |=> !busy)
    `ATS_ASSERT(a_no_table_write_in_walk, in_walk |-> !jl_we)
    `ATS_ASSERT(a_walk_steps_down, in_qv |=> (!busy || (r_j == $past(j_dn))))

endmodule
